### sv/dioc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioc_pkg
// Shared types and constants of the display idle dim/off controller: mode
// codes, register indexes, configuration, classified item and result beats.
// ----------------------------------------------------------------------------
package dioc_pkg;

  // mode codes
  localparam logic [1:0] MODE_ACTIVE = 2'd0;
  localparam logic [1:0] MODE_DIMMED = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;
  localparam logic [1:0] MODE_WAKING = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_DIM_TIMEOUT   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_OFF_TIMEOUT   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_WAKE_BRIGHT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FADE_IN       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FADE_OUT      = 3'd4;
  localparam int unsigned CFG_DW = 16;

  // command codes
  localparam logic CMD_IDLE_CHECK = 1'b0;
  localparam logic CMD_TOUCH      = 1'b1;

  // fixed constants
  localparam logic [47:0] WAKE_HOLD_US = 48'd250000;
  localparam logic [6:0]  DIM_LEVEL    = 7'd10;
  localparam logic [6:0]  FULL_LEVEL   = 7'd100;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

  typedef struct packed {
    logic [15:0] dim_timeout_sec;
    logic [15:0] off_timeout_sec;
    logic [6:0]  wake_brightness;
    logic [15:0] fade_in_msec;
    logic [15:0] fade_out_msec;
  } cfg_t;

  // item after classification by the front end
  typedef struct packed {
    logic        command;
    logic        is_press;
    logic        dim_en;
    logic        off_en;
    logic        ge_dim;
    logic        ge_off;
    logic        ge_sum;
    logic [47:0] time_usec;
  } item_t;

  typedef struct packed {
    logic       pass_event;
    logic       fade_start;
    logic [6:0] fade_level;
    logic [15:0] fade_time_msec;
    logic       fade_abort;
    logic       off_timer_start;
    logic       off_timer_cancel;
    logic       display_on;
    logic       activity_pulse;
    logic [1:0] mode_now;
  } res_t;

endpackage

### sv/dioc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioc_fifo
// Small register queue with push/full and pop/empty sides; head of the queue
// is shown on dout while empty is low.
// ----------------------------------------------------------------------------
module dioc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### sv/dioc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioc_front
// Front end: takes an input beat and classifies it against the idle
// thresholds, so the back end only needs flags and the time stamp.
// ----------------------------------------------------------------------------
module dioc_front (
  input  dioc_pkg::cfg_t  cfg,
  input  logic            command,
  input  logic            is_press,
  input  logic [31:0]     idle_msec,
  input  logic [47:0]     time_usec,
  output dioc_pkg::item_t item
);

  logic [25:0] dim_ms;
  logic [25:0] off_ms;
  logic [26:0] sum_ms;

  // thresholds in milliseconds
  assign dim_ms = 26'(cfg.dim_timeout_sec) * 26'(dioc_pkg::MS_PER_SEC);
  assign off_ms = 26'(cfg.off_timeout_sec) * 26'(dioc_pkg::MS_PER_SEC);
  assign sum_ms = 27'(dim_ms) + 27'(off_ms);

  // classified beat
  always_comb begin
    item.command   = command;
    item.is_press  = is_press;
    item.dim_en    = (cfg.dim_timeout_sec != '0);
    item.off_en    = (cfg.off_timeout_sec != '0);
    item.ge_dim    = (idle_msec >= 32'(dim_ms));
    item.ge_off    = (idle_msec >= 32'(off_ms));
    item.ge_sum    = (idle_msec >= 32'(sum_ms));
    item.time_usec = time_usec;
  end

endmodule

### sv/dioc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dioc_back
// Back end: holds the screen mode and wake time stamp, applies one classified
// beat per cycle while the result queue has room and produces its result.
// ----------------------------------------------------------------------------
module dioc_back (
  input  logic            clk,
  input  logic            rst,
  input  dioc_pkg::cfg_t  cfg,
  input  dioc_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_pop,
  input  logic            res_full,
  output logic            res_push,
  output dioc_pkg::res_t  res
);

  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [47:0] wake_time;
  logic [47:0] wake_time_next;
  logic [47:0] elapsed;
  logic        hold_done;
  logic        go;
  logic        go_off;
  logic        wake_go;
  logic [6:0]  level_sat;

  assign go       = item_valid && !res_full;
  assign item_pop = go;
  assign res_push = go;

  // time since wake, modular
  assign elapsed   = item.time_usec - wake_time;
  assign hold_done = (elapsed >= dioc_pkg::WAKE_HOLD_US);
  assign level_sat = (cfg.wake_brightness > dioc_pkg::FULL_LEVEL) ?
                     dioc_pkg::FULL_LEVEL : cfg.wake_brightness;

  // mode update and result
  always_comb begin
    res            = '0;
    mode_next      = mode;
    wake_time_next = wake_time;
    go_off         = 1'b0;
    wake_go        = 1'b0;
    if (item.command == dioc_pkg::CMD_IDLE_CHECK) begin
      case (mode)
        dioc_pkg::MODE_WAKING: begin
          if (hold_done) begin
            mode_next = dioc_pkg::MODE_ACTIVE;
          end
        end
        dioc_pkg::MODE_ACTIVE: begin
          if (item.dim_en && item.ge_dim) begin
            res.fade_start     = 1'b1;
            res.fade_level     = dioc_pkg::DIM_LEVEL;
            res.fade_time_msec = cfg.fade_out_msec;
            mode_next          = dioc_pkg::MODE_DIMMED;
          end else if (!item.dim_en && item.off_en && item.ge_off) begin
            go_off = 1'b1;
          end
        end
        dioc_pkg::MODE_DIMMED: begin
          if (item.off_en && item.ge_sum) begin
            go_off = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (go_off) begin
        res.fade_start      = 1'b1;
        res.fade_level      = '0;
        res.fade_time_msec  = cfg.fade_out_msec;
        res.off_timer_start = 1'b1;
        mode_next           = dioc_pkg::MODE_OFF;
      end
    end else begin
      if (mode == dioc_pkg::MODE_ACTIVE) begin
        res.pass_event = 1'b1;
      end else if (mode != dioc_pkg::MODE_WAKING && item.is_press) begin
        wake_go              = 1'b1;
        res.fade_abort       = 1'b1;
        res.off_timer_cancel = 1'b1;
        res.display_on       = (mode == dioc_pkg::MODE_OFF);
        res.fade_start       = 1'b1;
        res.fade_level       = level_sat;
        res.fade_time_msec   = cfg.fade_in_msec;
        res.activity_pulse   = 1'b1;
        mode_next            = dioc_pkg::MODE_WAKING;
        wake_time_next       = item.time_usec;
      end
    end
    res.mode_now = mode_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= dioc_pkg::MODE_WAKING;
      wake_time <= '0;
    end else if (go) begin
      mode      <= mode_next;
      wake_time <= wake_time_next;
    end
  end

  // a passed touch only ever comes out of active mode
  a_pass_active: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.pass_event) |-> (res.mode_now == dioc_pkg::MODE_ACTIVE))
    else $error("touch passed outside active mode");

  // wake time moves only on a wake press
  a_wake_stamp: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(wake_time)) |-> $past(go && wake_go))
    else $error("wake time changed without a wake");

  // waking is left only through an idle check that sees the hold elapsed
  a_wake_hold: assert property (@(posedge clk) disable iff (rst)
    (mode == dioc_pkg::MODE_WAKING && !(go && !item.command && hold_done))
    |=> (mode == dioc_pkg::MODE_WAKING))
    else $error("waking left early");

endmodule

### sv/display_idle_dim_off_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_idle_dim_off_controller
// Screen protection controller: idle checks and touch beats in, backlight,
// timer and panel requests out, one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   input queue side: drive command, is_press, idle_msec, time_usec and raise
//   push; the beat is taken at a clock edge with push high and full low.
//   result queue side: while empty is low the oldest result sits on the
//   result ports; it is taken at a clock edge with pop high.
//   configuration: cfg_wr_en with cfg_addr and cfg_wdata writes one register
//   (0 dim timeout, 1 off timeout, 2 wake brightness, 3 fade in, 4 fade out)
//   at the edge; other indexes are ignored. Write only while idle.
// Flow:
//   a beat is classified as it enters the item queue; the back end applies
//   the queue head to the mode and wake time registers and pushes its result
//   into the result queue, whose head shows on the result ports. One beat
//   per cycle is sustained while the result queue has room.
// Reset: synchronous, clears both queues, mode starts in waking with wake
//   time 0 and the registers take their default values.
// Stall: when the result queue fills the back end holds, the front queue
//   fills behind it and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module display_idle_dim_off_controller #(
  parameter int unsigned QUEUE_DEPTH = 2,
  parameter int unsigned OUT_DEPTH   = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [dioc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [dioc_pkg::CFG_DW-1:0]   cfg_wdata,
  // input beats
  input  logic                          push,
  output logic                          full,
  input  logic                          command,
  input  logic                          is_press,
  input  logic [31:0]                   idle_msec,
  input  logic [47:0]                   time_usec,
  // result beats
  output logic                          empty,
  input  logic                          pop,
  output logic                          pass_event,
  output logic                          fade_start,
  output logic [6:0]                    fade_level,
  output logic [15:0]                   fade_time_msec,
  output logic                          fade_abort,
  output logic                          off_timer_start,
  output logic                          off_timer_cancel,
  output logic                          display_on,
  output logic                          activity_pulse,
  output logic [1:0]                    mode_now
);

  localparam int unsigned ITEM_W = $bits(dioc_pkg::item_t);
  localparam int unsigned RES_W  = $bits(dioc_pkg::res_t);

  dioc_pkg::cfg_t  cfg;
  dioc_pkg::item_t item_in;
  dioc_pkg::item_t item_q;
  dioc_pkg::res_t  res_in;
  dioc_pkg::res_t  res_q;
  logic            q_empty;
  logic            q_pop;
  logic            r_full;
  logic            r_push;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_timeout_sec <= 16'd60;
      cfg.off_timeout_sec <= 16'd120;
      cfg.wake_brightness <= 7'd100;
      cfg.fade_in_msec    <= 16'd500;
      cfg.fade_out_msec   <= 16'd500;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        dioc_pkg::REG_DIM_TIMEOUT: cfg.dim_timeout_sec <= cfg_wdata;
        dioc_pkg::REG_OFF_TIMEOUT: cfg.off_timeout_sec <= cfg_wdata;
        dioc_pkg::REG_WAKE_BRIGHT: cfg.wake_brightness <= cfg_wdata[6:0];
        dioc_pkg::REG_FADE_IN:     cfg.fade_in_msec    <= cfg_wdata;
        dioc_pkg::REG_FADE_OUT:    cfg.fade_out_msec   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front end classification
  dioc_front u_front (
    .cfg       (cfg),
    .command   (command),
    .is_press  (is_press),
    .idle_msec (idle_msec),
    .time_usec (time_usec),
    .item      (item_in)
  );

  // queue between front and back
  dioc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item_in),
    .full  (full),
    .pop   (q_pop),
    .dout  (item_q),
    .empty (q_empty)
  );

  // back end mode state
  dioc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item_q),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .res_full   (r_full),
    .res_push   (r_push),
    .res        (res_in)
  );

  // result queue
  dioc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (res_in),
    .full  (r_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  // result ports
  assign pass_event       = res_q.pass_event;
  assign fade_start       = res_q.fade_start;
  assign fade_level       = res_q.fade_level;
  assign fade_time_msec   = res_q.fade_time_msec;
  assign fade_abort       = res_q.fade_abort;
  assign off_timer_start  = res_q.off_timer_start;
  assign off_timer_cancel = res_q.off_timer_cancel;
  assign display_on       = res_q.display_on;
  assign activity_pulse   = res_q.activity_pulse;
  assign mode_now         = res_q.mode_now;

  // a result without a fade request carries no level or time
  a_fade_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && !fade_start) |-> (fade_level == '0 && fade_time_msec == '0))
    else $error("fade fields set without a fade");

endmodule
